/* rtl/vtba_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtba_pkg
// shared widths, angle constants and the cordic arctangent table
// ----------------------------------------------------------------------------
package vtba_pkg;

    localparam int IN_W       = 32;   // dx / dz width
    localparam int HEAD_W     = 16;   // heading width
    localparam int ANGLE_W    = 33;   // signed angle accumulator, pi == 2^31
    localparam int TABLE_LEN  = 25;   // entries in the arctangent table
    localparam int IDX_W      = 5;    // bits to index the table
    localparam int POS_W      = 5;    // bit position inside an IN_W word

    localparam int DEF_CORDIC_STAGES = 16;
    localparam int DEF_VECTOR_WIDTH  = 32;

    localparam logic signed [ANGLE_W-1:0] ANGLE_HALF_PI = 33'sh0_4000_0000;
    localparam logic        [ANGLE_W-1:0] ANGLE_PI      = 33'h0_8000_0000;

    // side information that rides along with every vector
    typedef struct packed {
        logic x_neg;
        logic z_neg;
        logic ax_zero;
        logic az_zero;
    } t_ctl;

    // atan(2^-i) * 2^31 / pi, rounded
    function automatic logic [31:0] atan_entry(input logic [IDX_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/vtba_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtba_if
// valid / ready channels for vector requests and heading results
// ----------------------------------------------------------------------------
interface vtba_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [vtba_pkg::IN_W-1:0]     dx;
    logic signed [vtba_pkg::IN_W-1:0]     dz;

    modport source (output valid, output dx, output dz, input ready);
    modport sink   (input valid, input dx, input dz, output ready);
endinterface

interface vtba_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [vtba_pkg::HEAD_W-1:0]          heading;

    modport source (output valid, output heading, input ready);
    modport sink   (input valid, input heading, output ready);
endinterface

/* rtl/vtba_prep.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtba_prep
// magnitude / quadrant fold, top-bit search and normalizing shift, 3 stages
// ----------------------------------------------------------------------------
module vtba_prep #(
    parameter int VECTOR_WIDTH = vtba_pkg::DEF_VECTOR_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic signed [vtba_pkg::IN_W-1:0]   i_dx,
    input  logic signed [vtba_pkg::IN_W-1:0]   i_dz,
    output logic                               o_valid,
    output vtba_pkg::t_ctl                     o_ctl,
    output logic [VECTOR_WIDTH-1:0]            o_x,
    output logic [VECTOR_WIDTH-1:0]            o_y
);

    localparam int WIDE_W = vtba_pkg::IN_W + VECTOR_WIDTH - 1;

    // stage a: fold to magnitudes
    logic                           r_va;
    vtba_pkg::t_ctl                 r_ctl_a;
    logic [vtba_pkg::IN_W-1:0]      r_ax_a;
    logic [vtba_pkg::IN_W-1:0]      r_az_a;
    vtba_pkg::t_ctl                 n_ctl_a;
    logic [vtba_pkg::IN_W-1:0]      n_ax_a;
    logic [vtba_pkg::IN_W-1:0]      n_az_a;

    // stage b: top set bit of the larger magnitude
    logic                           r_vb;
    vtba_pkg::t_ctl                 r_ctl_b;
    logic [vtba_pkg::IN_W-1:0]      r_ax_b;
    logic [vtba_pkg::IN_W-1:0]      r_az_b;
    logic [vtba_pkg::POS_W-1:0]     r_pos_b;
    logic [vtba_pkg::IN_W-1:0]      w_max;
    logic [vtba_pkg::POS_W-1:0]     n_pos_b;

    // stage c: shift so the top bit lands on VECTOR_WIDTH-1
    logic                           r_vc;
    vtba_pkg::t_ctl                 r_ctl_c;
    logic [VECTOR_WIDTH-1:0]        r_x_c;
    logic [VECTOR_WIDTH-1:0]        r_y_c;
    logic [WIDE_W-1:0]              w_wide_z;
    logic [WIDE_W-1:0]              w_wide_x;

    always_comb begin
        n_ctl_a.x_neg   = i_dx[vtba_pkg::IN_W-1];
        n_ctl_a.z_neg   = i_dz[vtba_pkg::IN_W-1];
        n_ctl_a.ax_zero = (i_dx == '0);
        n_ctl_a.az_zero = (i_dz == '0);
        // two's complement negate of the most negative value gives 2^31 unsigned
        n_ax_a = n_ctl_a.x_neg ? (~i_dx + 1'b1) : i_dx;
        n_az_a = n_ctl_a.z_neg ? (~i_dz + 1'b1) : i_dz;
    end

    always_comb begin
        w_max   = (r_az_a > r_ax_a) ? r_az_a : r_ax_a;
        n_pos_b = '0;
        for (int i = 1; i < vtba_pkg::IN_W; i++) begin
            if (w_max[i]) begin
                n_pos_b = vtba_pkg::POS_W'(i);
            end
        end
    end

    // value * 2^(VW-1) / 2^pos covers both the left and the truncating right shift
    assign w_wide_z = {r_az_b, {(VECTOR_WIDTH-1){1'b0}}} >> r_pos_b;
    assign w_wide_x = {r_ax_b, {(VECTOR_WIDTH-1){1'b0}}} >> r_pos_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl_a <= n_ctl_a;
            r_ax_a  <= n_ax_a;
            r_az_a  <= n_az_a;
            r_ctl_b <= r_ctl_a;
            r_ax_b  <= r_ax_a;
            r_az_b  <= r_az_a;
            r_pos_b <= n_pos_b;
            r_ctl_c <= r_ctl_b;
            r_x_c   <= w_wide_z[VECTOR_WIDTH-1:0];
            r_y_c   <= w_wide_x[VECTOR_WIDTH-1:0];
        end
    end

    assign o_valid = r_vc;
    assign o_ctl   = r_ctl_c;
    assign o_x     = r_x_c;
    assign o_y     = r_y_c;

endmodule

/* rtl/vtba_cordic_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtba_cordic_stage
// one registered cordic vectoring micro-rotation
// ----------------------------------------------------------------------------
module vtba_cordic_stage #(
    parameter int VECTOR_WIDTH = vtba_pkg::DEF_VECTOR_WIDTH,
    parameter int STAGE        = 0
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  vtba_pkg::t_ctl                         i_ctl,
    input  logic signed [VECTOR_WIDTH+2:0]         i_x,
    input  logic signed [VECTOR_WIDTH+2:0]         i_y,
    input  logic signed [vtba_pkg::ANGLE_W-1:0]    i_z,
    output logic                                   o_valid,
    output vtba_pkg::t_ctl                         o_ctl,
    output logic signed [VECTOR_WIDTH+2:0]         o_x,
    output logic signed [VECTOR_WIDTH+2:0]         o_y,
    output logic signed [vtba_pkg::ANGLE_W-1:0]    o_z
);

    localparam logic signed [vtba_pkg::ANGLE_W-1:0] ATAN =
        $signed({1'b0, vtba_pkg::atan_entry(vtba_pkg::IDX_W'(STAGE))});

    logic                                 r_valid;
    vtba_pkg::t_ctl                       r_ctl;
    logic signed [VECTOR_WIDTH+2:0]       r_x;
    logic signed [VECTOR_WIDTH+2:0]       r_y;
    logic signed [vtba_pkg::ANGLE_W-1:0]  r_z;
    logic signed [VECTOR_WIDTH+2:0]       w_xs;
    logic signed [VECTOR_WIDTH+2:0]       w_ys;
    logic signed [VECTOR_WIDTH+2:0]       n_x;
    logic signed [VECTOR_WIDTH+2:0]       n_y;
    logic signed [vtba_pkg::ANGLE_W-1:0]  n_z;

    assign w_xs = i_x >>> STAGE;
    assign w_ys = i_y >>> STAGE;

    always_comb begin
        // rotate toward the x axis, direction from the sign of y
        if (!i_y[VECTOR_WIDTH+2]) begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + ATAN;
        end else begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl <= i_ctl;
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule

/* rtl/vtba_finish.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtba_finish
// clamp, axis cases, quadrant restore and output register
// ----------------------------------------------------------------------------
module vtba_finish (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  vtba_pkg::t_ctl                         i_ctl,
    input  logic signed [vtba_pkg::ANGLE_W-1:0]    i_z,
    output logic                                   o_valid,
    output logic [vtba_pkg::HEAD_W-1:0]            o_heading
);

    logic                                 r_valid;
    logic [vtba_pkg::HEAD_W-1:0]          r_heading;
    logic signed [vtba_pkg::ANGLE_W-1:0]  w_clamp;
    logic [vtba_pkg::ANGLE_W-1:0]         w_ang;
    logic [vtba_pkg::ANGLE_W-1:0]         w_fold;
    logic [vtba_pkg::HEAD_W-1:0]          w_mag;
    logic [vtba_pkg::HEAD_W-1:0]          n_heading;

    always_comb begin
        if (i_z < 0) begin
            w_clamp = '0;
        end else if (i_z > vtba_pkg::ANGLE_HALF_PI) begin
            w_clamp = vtba_pkg::ANGLE_HALF_PI;
        end else begin
            w_clamp = i_z;
        end

        // vector on an axis skips the cordic result
        if (i_ctl.ax_zero) begin
            w_ang = '0;
        end else if (i_ctl.az_zero) begin
            w_ang = vtba_pkg::ANGLE_HALF_PI;
        end else begin
            w_ang = w_clamp;
        end

        w_fold    = i_ctl.z_neg ? (vtba_pkg::ANGLE_PI - w_ang) : w_ang;
        w_mag     = w_fold[31:16];
        n_heading = i_ctl.x_neg ? (~w_mag + 1'b1) : w_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_heading <= n_heading;
        end
    end

    assign o_valid   = r_valid;
    assign o_heading = r_heading;

endmodule

/* rtl/vector_to_binary_angle.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_to_binary_angle
// direction of a signed (dx, dz) vector as a 16-bit binary angle
// ----------------------------------------------------------------------------
// usage:
//   i_req carries one vector request (dx, dz, 32-bit signed) with valid/ready,
//   o_res returns one heading (16-bit, 65536 per turn, measured from +z
//   toward +x) per request, in request order
//   a request passes the prep stages, the cordic stages and the finish
//   register before o_res.valid; throughput is one request per cycle unless
//   the output stalls; every stage holds one request
//   the pipeline moves as a whole: it advances whenever the output register
//   is empty or being taken, so i_req.ready follows o_res.ready while a
//   result waits, and a bubble in the output register never blocks input
//   when the receiver stalls every stage holds its contents, nothing is lost
//   or repeated
//   reset (synchronous, active low) clears all valid bits; the pipeline is
//   ready to take a request in the first cycle after reset
//   zero vector gives heading 0
// ----------------------------------------------------------------------------
module vector_to_binary_angle #(
    parameter int CORDIC_STAGES = vtba_pkg::DEF_CORDIC_STAGES,
    parameter int VECTOR_WIDTH  = vtba_pkg::DEF_VECTOR_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    vtba_in_if.sink          i_req,
    vtba_out_if.source       o_res
);

    // stages past the end of the arctangent table add nothing
    localparam int NSTG = (CORDIC_STAGES < vtba_pkg::TABLE_LEN) ?
                          CORDIC_STAGES : vtba_pkg::TABLE_LEN;
    localparam int CW   = VECTOR_WIDTH + 3;   // room for cordic gain growth

    logic                                 w_en;
    logic                                 w_out_valid;
    logic [vtba_pkg::HEAD_W-1:0]          w_heading;

    // normalized vector out of the front end
    logic                                 w_prep_valid;
    vtba_pkg::t_ctl                       w_prep_ctl;
    logic [VECTOR_WIDTH-1:0]              w_prep_x;
    logic [VECTOR_WIDTH-1:0]              w_prep_y;

    // links between cordic stages, index 0 is the stage input
    logic                                 w_valid [0:NSTG];
    vtba_pkg::t_ctl                       w_ctl   [0:NSTG];
    logic signed [CW-1:0]                 w_x     [0:NSTG];
    logic signed [CW-1:0]                 w_y     [0:NSTG];
    logic signed [vtba_pkg::ANGLE_W-1:0]  w_z     [0:NSTG];

    // whole pipeline steps when the output slot is free or being emptied
    assign w_en        = !w_out_valid || o_res.ready;
    assign i_req.ready = w_en;

    vtba_prep #(
        .VECTOR_WIDTH (VECTOR_WIDTH)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_req.valid),
        .i_dx    (i_req.dx),
        .i_dz    (i_req.dz),
        .o_valid (w_prep_valid),
        .o_ctl   (w_prep_ctl),
        .o_x     (w_prep_x),
        .o_y     (w_prep_y)
    );

    // cordic x takes |dz|, y takes |dx|; both start non-negative
    assign w_valid[0] = w_prep_valid;
    assign w_ctl[0]   = w_prep_ctl;
    assign w_x[0]     = $signed({3'b000, w_prep_x});
    assign w_y[0]     = $signed({3'b000, w_prep_y});
    assign w_z[0]     = '0;

    for (genvar g = 0; g < NSTG; g++) begin : g_cordic
        vtba_cordic_stage #(
            .VECTOR_WIDTH (VECTOR_WIDTH),
            .STAGE        (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_ctl   (w_ctl[g]),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_z     (w_z[g]),
            .o_valid (w_valid[g+1]),
            .o_ctl   (w_ctl[g+1]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_z     (w_z[g+1])
        );
    end

    // final angle handling, also serves as the output register
    vtba_finish u_finish (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (w_valid[NSTG]),
        .i_ctl     (w_ctl[NSTG]),
        .i_z       (w_z[NSTG]),
        .o_valid   (w_out_valid),
        .o_heading (w_heading)
    );

    assign o_res.valid   = w_out_valid;
    assign o_res.heading = w_heading;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for vector_to_binary_angle: every accepted (dx, dz)
// request is run through a bit-exact cordic model of its own, and each heading
// that leaves the block is compared in order against that prediction while
// both handshake sides, outside the burst, idle and stall at random
// ----------------------------------------------------------------------------
module tb_top;

    localparam int IN_W          = vtba_pkg::IN_W;
    localparam int HEAD_W        = vtba_pkg::HEAD_W;
    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int STALL_PCT     = 21;
    localparam int WATCHDOG_MAX  = 2000;   // cycles with no request or result moving
    localparam int DRAIN_CYCLES  = 40;
    localparam int NORM_MSB      = vtba_pkg::DEF_VECTOR_WIDTH - 1;
    localparam int STAGES_RUN    =
        (vtba_pkg::DEF_CORDIC_STAGES < vtba_pkg::TABLE_LEN) ? vtba_pkg::DEF_CORDIC_STAGES
                                                            : vtba_pkg::TABLE_LEN;
    localparam longint QUARTER_TURN = 64'h4000_0000;
    localparam longint HALF_TURN    = 64'h8000_0000;

    localparam logic signed [IN_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [IN_W-1:0] MOST_POS = 32'sh7fff_ffff;

    // arctangent of 2^-i in units of pi / 2^31, index 0 in the low word
    localparam logic [24:0][31:0] ARCTAN_STEP = {
        32'd41,        32'd81,        32'd163,       32'd326,       32'd652,
        32'd1304,      32'd2608,      32'd5215,      32'd10430,     32'd20861,
        32'd41722,     32'd83443,     32'd166886,    32'd333772,    32'd667544,
        32'd1335087,   32'd2670163,   32'd5340245,   32'd10679838,  32'd21354465,
        32'd42667331,  32'd85004756,  32'd167458907, 32'd316933406, 32'd536870912
    };

    typedef struct {
        logic signed [IN_W-1:0] dx;
        logic signed [IN_W-1:0] dz;
        logic [HEAD_W-1:0]      heading;
    } t_in_flight;

    logic i_clk;
    logic i_rst_n;

    vtba_in_if  req_if ();
    vtba_out_if res_if ();

    vector_to_binary_angle dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    t_in_flight headings_in_flight[$];
    t_in_flight oldest;
    int         mismatch_count = 0;
    int         quiet_cycles   = 0;
    logic       no_gaps;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // bit-exact heading: fold into the first quadrant, normalize, run the
    // vectoring cordic, clamp, then restore the quadrant
    function automatic logic [HEAD_W-1:0] binary_angle_of(
        input logic signed [IN_W-1:0] dx,
        input logic signed [IN_W-1:0] dz
    );
        logic [63:0]        ax;
        logic [63:0]        az;
        logic [63:0]        mag;
        logic signed [63:0] cx;
        logic signed [63:0] cy;
        logic signed [63:0] sx;
        logic signed [63:0] sy;
        longint             ang;
        longint             turn;
        int                 msb;
        int                 b;
        ax = dx[IN_W-1] ? 64'h1_0000_0000 - {32'd0, dx} : {32'd0, dx};
        az = dz[IN_W-1] ? 64'h1_0000_0000 - {32'd0, dz} : {32'd0, dz};
        if (ax == 0 && az == 0) begin
            return '0;
        end
        if (ax == 0) begin
            ang = 0;
        end else if (az == 0) begin
            ang = QUARTER_TURN;
        end else begin
            cx  = az;
            cy  = ax;
            mag = (az > ax) ? az : ax;
            msb = 0;
            for (b = 0; b < 64; b++) begin
                if (mag[b]) msb = b;
            end
            // both magnitudes are positive here, so a plain shift is enough
            if (msb < NORM_MSB) begin
                cx = cx << (NORM_MSB - msb);
                cy = cy << (NORM_MSB - msb);
            end else begin
                cx = cx >> (msb - NORM_MSB);
                cy = cy >> (msb - NORM_MSB);
            end
            ang = 0;
            for (b = 0; b < STAGES_RUN; b++) begin
                sx = cx >>> b;
                sy = cy >>> b;
                if (!cy[63]) begin
                    cx  = cx + sy;
                    cy  = cy - sx;
                    ang = ang + longint'(ARCTAN_STEP[b]);
                end else begin
                    cx  = cx - sy;
                    cy  = cy + sx;
                    ang = ang - longint'(ARCTAN_STEP[b]);
                end
            end
            if (ang < 0) ang = 0;
            if (ang > QUARTER_TURN) ang = QUARTER_TURN;
        end
        if (dz[IN_W-1]) ang = HALF_TURN - ang;
        turn = ang >>> 16;
        if (dx[IN_W-1]) turn = (65536 - turn) & 16'hffff;
        return turn[HEAD_W-1:0];
    endfunction

    // one request: optional idle cycles, then hold valid until ready
    task automatic send_vector(input logic signed [IN_W-1:0] dx,
                               input logic signed [IN_W-1:0] dz);
        t_in_flight item;
        if (!no_gaps) begin
            while ($urandom_range(0, 99) < STALL_PCT) begin
                req_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        req_if.valid <= 1'b1;
        req_if.dx    <= dx;
        req_if.dz    <= dz;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        item.dx      = dx;
        item.dz      = dz;
        item.heading = binary_angle_of(dx, dz);
        headings_in_flight.push_back(item);
    endtask

    // magnitude of random bit length so the normalizing shift varies over its range
    function automatic logic signed [IN_W-1:0] scaled_component();
        logic signed [IN_W-1:0] v;
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 99) == 0) v = MOST_NEG;
        else if ($urandom_range(0, 1) == 1) v = -v;
        return v;
    endfunction

    task automatic test_axes_and_extremes();
        send_vector(0, 0);
        send_vector(0, 1);
        send_vector(0, -1);
        send_vector(1, 0);
        send_vector(-1, 0);
        send_vector(0, MOST_POS);
        send_vector(0, MOST_NEG);
        send_vector(MOST_POS, 0);
        send_vector(MOST_NEG, 0);
        send_vector(MOST_NEG, MOST_NEG);
        send_vector(MOST_POS, MOST_POS);
        send_vector(MOST_NEG, MOST_POS);
        send_vector(MOST_POS, MOST_NEG);
        send_vector(MOST_NEG, 1);
        send_vector(-1, MOST_NEG);
        send_vector(MOST_POS, -1);
        send_vector(1, MOST_POS);
        send_vector(-1, -1);
        send_vector(1, -1);
        send_vector(-1, 1);
        send_vector(1, 1);
        send_vector(5, -3);
        send_vector(-32'sd65536, 32'sd113512);
        send_vector(32'sh0001_0000, -32'sh0000_8000);
    endtask

    task automatic test_random_full(input int count);
        repeat (count) send_vector($urandom, $urandom);
    endtask

    task automatic test_random_scaled(input int count);
        repeat (count) send_vector(scaled_component(), scaled_component());
    endtask

    // one component tiny or zero against a large one, both orientations
    task automatic test_near_axes(input int count);
        logic signed [IN_W-1:0] big;
        logic signed [IN_W-1:0] tiny;
        repeat (count) begin
            big  = scaled_component();
            tiny = $urandom_range(0, 8) - 4;
            if ($urandom_range(0, 1) == 1) send_vector(big, tiny);
            else send_vector(tiny, big);
        end
    endtask

    // long back-to-back run with no stalls on either side
    task automatic test_burst(input int count);
        no_gaps <= 1'b1;
        repeat (count) send_vector($urandom, scaled_component());
        no_gaps <= 1'b0;
    endtask

    // receiver stalls at random outside the burst
    always @(posedge i_clk) begin
        res_if.ready <= no_gaps || ($urandom_range(0, 99) >= STALL_PCT);
    end

    // compare each heading leaving the block with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (headings_in_flight.size() == 0) begin
                $display("%0t: heading %0d with no request in flight", $time,
                         res_if.heading);
                mismatch_count++;
            end else begin
                oldest = headings_in_flight.pop_front();
                if (res_if.heading !== oldest.heading) begin
                    $display("%0t: dx=%0d dz=%0d heading expected %0d actual %0d",
                             $time, oldest.dx, oldest.dz, oldest.heading,
                             res_if.heading);
                    mismatch_count++;
                end
            end
        end
    end

    // give up when nothing has moved for too long
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n      <= 1'b0;
        no_gaps      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.dx    <= '0;
        req_if.dz    <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_axes_and_extremes();
        test_random_full(600);
        test_random_scaled(700);
        test_near_axes(250);
        test_burst(400);

        req_if.valid <= 1'b0;
        while (headings_in_flight.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
